@@ src/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg: shared types and codes of the sorted list
// Word layouts for the command and result channels and the status codes.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 6;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_DROPPED  = 2'd2;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_TOGGLE = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic                     is_element;
		logic [1:0]               status;
		logic signed [DATA_W-1:0] element;
		logic [COUNT_W-1:0]       entry_count;
		logic                     last;
	} out_word_t;

endpackage

@@ src/slt_ram.sv @@
// ----------------------------------------------------------------------------
// slt_ram: entry store of the sorted list
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module slt_ram import slt_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/sorted_list_toggle.sv @@
// ----------------------------------------------------------------------------
// sorted_list_toggle: ascending sorted list with insert, toggle and dump
// Keeps up to DEPTH signed words in order in one memory with a single read
// and a single write port. A load word inserts its value ahead of equal
// entries; a toggle word removes the first equal entry or inserts the value,
// then dumps the list; an insert into a full list is dropped. Busy stays high
// from acceptance until the last result word has been registered; results
// come one per cycle with a strobe and cannot be held off. The single memory
// read port is stepped one entry per cycle through search, move and dump.
// ----------------------------------------------------------------------------
module sorted_list_toggle import slt_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  item,
	output logic      result_strobe,
	output out_word_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_PLACE  = 3'd3;
	localparam logic [2:0] S_STATUS = 3'd4;
	localparam logic [2:0] S_DUMP   = 3'd5;

	logic [2:0]               state_q;
	logic                     cmd_q;
	logic signed [DATA_W-1:0] value_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            moves_q;
	logic                     up_q;
	logic [CW-1:0]            pos_q;
	logic [1:0]               status_q;
	logic                     rv_s1;
	logic [AW-1:0]            addr_s1;
	out_word_t                result_q;
	logic                     result_strobe_q;

	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              hit;
	logic              scan_done;
	logic              scan_found;
	logic [CW-1:0]     scan_pos;
	logic              dump_last;

	slt_ram #(.DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign hit        = rv_s1 && ($signed(rd_data) >= value_q);
	assign scan_done  = hit || ((idx_q == count_q) && !rv_s1);
	assign scan_found = hit && (rd_data == value_q);
	assign scan_pos   = hit ? CW'(addr_s1) : count_q;
	assign dump_last  = CW'(addr_s1) == (count_q - ONE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = pos_q[AW-1:0];
		wr_data = value_q;
		unique case (state_q)
			S_SCAN: begin
				rd_en = (idx_q < count_q) && !hit;
			end
			S_SHIFT: begin
				rd_en   = moves_q != '0;
				wr_en   = rv_s1;
				wr_addr = up_q ? addr_s1 + AW'(1) : addr_s1 - AW'(1);
				wr_data = rd_data;
			end
			S_PLACE: begin
				wr_en = 1'b1;
			end
			S_STATUS: begin
				rd_en   = (cmd_q == CMD_TOGGLE) && (count_q != '0);
				rd_addr = '0;
			end
			S_DUMP: begin
				rd_en = idx_q < count_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			idx_q           <= '0;
			moves_q         <= '0;
			up_q            <= 1'b0;
			rv_s1           <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			rv_s1           <= rd_en;
			result_strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if ((cmd_q == CMD_TOGGLE) && scan_found) begin
							up_q    <= 1'b0;
							idx_q   <= scan_pos + ONE;
							moves_q <= count_q - scan_pos - ONE;
							count_q <= count_q - ONE;
							state_q <= S_SHIFT;
						end else if (count_q == FULL) begin
							state_q <= S_STATUS;
						end else begin
							up_q    <= 1'b1;
							idx_q   <= count_q - ONE;
							moves_q <= count_q - scan_pos;
							count_q <= count_q + ONE;
							state_q <= S_SHIFT;
						end
					end else if (rd_en) begin
						idx_q <= idx_q + ONE;
					end
				end
				S_SHIFT: begin
					if (rd_en) begin
						idx_q   <= up_q ? idx_q - ONE : idx_q + ONE;
						moves_q <= moves_q - ONE;
					end else if (!rv_s1) begin
						state_q <= up_q ? S_PLACE : S_STATUS;
					end
				end
				S_PLACE: begin
					state_q <= S_STATUS;
				end
				S_STATUS: begin
					result_strobe_q <= 1'b1;
					idx_q           <= ONE;
					if ((cmd_q == CMD_LOAD) || (count_q == '0)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DUMP;
					end
				end
				S_DUMP: begin
					if (rd_en) begin
						idx_q <= idx_q + ONE;
					end
					if (rv_s1) begin
						result_strobe_q <= 1'b1;
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if ((state_q == S_IDLE) && start) begin
			cmd_q   <= item.cmd;
			value_q <= item.value;
		end
		if ((state_q == S_SCAN) && scan_done) begin
			pos_q <= scan_pos;
			if ((cmd_q == CMD_TOGGLE) && scan_found) begin
				status_q <= ST_REMOVED;
			end else if (count_q == FULL) begin
				status_q <= ST_DROPPED;
			end else begin
				status_q <= ST_INSERTED;
			end
		end
		if (state_q == S_STATUS) begin
			result_q.is_element  <= 1'b0;
			result_q.status      <= status_q;
			result_q.element     <= '0;
			result_q.entry_count <= COUNT_W'(count_q);
			result_q.last        <= (cmd_q == CMD_LOAD) || (count_q == '0);
		end else if ((state_q == S_DUMP) && rv_s1) begin
			result_q.is_element  <= 1'b1;
			result_q.status      <= status_q;
			result_q.element     <= rd_data;
			result_q.entry_count <= COUNT_W'(count_q);
			result_q.last        <= dump_last;
		end
	end

	assign busy          = state_q != S_IDLE;
	assign result_strobe = result_strobe_q;
	assign result        = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count above depth");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_strobe && result.last)
		else $error("block idle without a final result word");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHIFT) || (state_q == S_PLACE))
		else $error("memory write outside move or place");

	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.is_element |-> $past(result_strobe))
		else $error("gap in list dump");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

endmodule
